[hw/rtl/pd_pkg.sv]
// shared types, constants and helpers of the polyline densifier
package pd_pkg;

    // coordinate and register widths
    localparam int COORD_W = 32;
    localparam int DELTA_W = COORD_W + 1;
    localparam int POS_W   = COORD_W + 2;
    localparam int RES_W   = 25;
    localparam int STEP_W  = RES_W - 1;

    // fixed point format and step floor
    localparam int FRAC_BITS = 16;
    localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'((((1 << FRAC_BITS) * 5) + 50) / 100);

    localparam logic [RES_W-1:0] GRID_RES_RESET = RES_W'(6554);

    // segment count limits
    localparam int PD_MAX_SEGMENTS = 64;
    localparam int CNT_W = 7;

    // long division of a delta magnitude by the segment count
    localparam int DIV_W  = COORD_W;
    localparam int DCNT_W = $clog2(DIV_W);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQA,
        F_SQB,
        F_SUM,
        F_SQL,
        F_CMP,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_FIX,
        B_EMIT
    } t_back_state;

    // one classified segment, ready to be interpolated
    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [CNT_W-1:0]          n;
        logic                      clip;
    } t_seg;

    // magnitude of a coordinate difference, always fits in COORD_W bits
    function automatic logic [COORD_W-1:0] abs_delta(input logic signed [DELTA_W-1:0] d);
        logic [DELTA_W-1:0] m;
        m = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
        return m[COORD_W-1:0];
    endfunction

endpackage

[hw/rtl/pd_pt_in_if.sv]
// waypoint input channel
interface pd_pt_in_if import pd_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      path_start;

    modport source (output valid, output point_x, output point_y, output path_start,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input path_start,
                    output ready);
endinterface

[hw/rtl/pd_pt_out_if.sv]
// densified point output channel
interface pd_pt_out_if import pd_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      last_of_run;
    logic                      clipped;

    modport source (output valid, output out_x, output out_y, output last_of_run,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input last_of_run,
                    input clipped, output ready);
endinterface

[hw/rtl/pd_front.sv]
// front: accepts waypoints, keeps the previous one and finds the segment count
module pd_front import pd_pkg::*; #(
    parameter int MAX_SEGMENTS = PD_MAX_SEGMENTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RES_W-1:0] i_grid_res,
    pd_pt_in_if.sink         i_pt,
    output logic             o_seg_valid,
    input  logic             i_seg_ready,
    output t_seg             o_seg
);

    localparam int K_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int LEN_W = STEP_W + K_W;
    localparam logic [K_W-1:0] K_MAX = K_W'(MAX_SEGMENTS);

    t_front_state r_state, n_state;
    logic r_have_prev, n_have_prev;
    logic signed [COORD_W-1:0] r_prev_x, n_prev_x;
    logic signed [COORD_W-1:0] r_prev_y, n_prev_y;
    t_seg r_seg, n_seg;
    logic [2*COORD_W-1:0] r_prod;
    logic [2*COORD_W:0] r_d2, n_d2;
    logic [K_W-1:0] r_k, n_k;
    logic [LEN_W-1:0] r_len, n_len;

    logic [STEP_W-1:0] half;
    logic [STEP_W-1:0] step;
    logic [COORD_W-1:0] mul_a;

    always_comb begin
        half = i_grid_res[RES_W-1:1];
        step = (half > STEP_MIN) ? half : STEP_MIN;
    end

    // one shared squarer
    always_comb begin
        case (r_state)
            F_SQA:   mul_a = abs_delta(r_seg.dx);
            F_SQB:   mul_a = abs_delta(r_seg.dy);
            default: mul_a = COORD_W'(r_len);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_a;
    end

    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_seg       = r_seg;
        n_d2        = r_d2;
        n_k         = r_k;
        n_len       = r_len;
        i_pt.ready  = (r_state == F_IDLE);
        o_seg_valid = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_pt.valid) begin
                    n_prev_x    = i_pt.point_x;
                    n_prev_y    = i_pt.point_y;
                    n_have_prev = 1'b1;
                    if (!r_have_prev || i_pt.path_start) begin
                        n_seg.base_x = i_pt.point_x;
                        n_seg.base_y = i_pt.point_y;
                        n_seg.dx     = '0;
                        n_seg.dy     = '0;
                        n_seg.n      = CNT_W'(1);
                        n_seg.clip   = 1'b0;
                        n_state      = F_PUSH;
                    end else begin
                        n_seg.base_x = r_prev_x;
                        n_seg.base_y = r_prev_y;
                        n_seg.dx     = {i_pt.point_x[COORD_W-1], i_pt.point_x}
                                     - {r_prev_x[COORD_W-1], r_prev_x};
                        n_seg.dy     = {i_pt.point_y[COORD_W-1], i_pt.point_y}
                                     - {r_prev_y[COORD_W-1], r_prev_y};
                        n_state      = F_SQA;
                    end
                end
            end
            F_SQA: n_state = F_SQB;
            F_SQB: begin
                n_d2    = {1'b0, r_prod};
                n_state = F_SUM;
            end
            F_SUM: begin
                n_d2    = r_d2 + {1'b0, r_prod};
                n_k     = K_W'(1);
                n_len   = LEN_W'(step);
                n_state = F_SQL;
            end
            F_SQL: n_state = F_CMP;
            F_CMP: begin
                if ({1'b0, r_prod} >= r_d2) begin
                    n_seg.n    = CNT_W'(r_k);
                    n_seg.clip = 1'b0;
                    n_state    = F_PUSH;
                end else if (r_k == K_MAX) begin
                    n_seg.n    = CNT_W'(r_k);
                    n_seg.clip = 1'b1;
                    n_state    = F_PUSH;
                end else begin
                    n_k     = r_k + K_W'(1);
                    n_len   = r_len + LEN_W'(step);
                    n_state = F_SQL;
                end
            end
            F_PUSH: begin
                o_seg_valid = 1'b1;
                if (i_seg_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_seg = r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
        r_d2  <= n_d2;
        r_k   <= n_k;
        r_len <= n_len;
    end

`ifndef ASSERT_OFF
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_SQL || r_state == F_CMP) |-> (r_k != '0 && r_k <= K_MAX))
        else $error("segment search count out of range");
`endif

endmodule

[hw/rtl/pd_queue.sv]
// short queue of classified segments between front and back
module pd_queue import pd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_seg i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_seg o_pop_data
);

    t_seg r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic push, pop;

    always_comb begin
        o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
        o_pop_valid  = (r_count != '0);
        o_pop_data   = r_mem[r_rd_ptr];
        push = i_push_valid && o_push_ready;
        pop  = o_pop_valid && i_pop_ready;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");
`endif

endmodule

[hw/rtl/pd_back.sv]
// back: divides the segment by its count and emits the evenly spaced points
module pd_back import pd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_seg_valid,
    output logic o_seg_ready,
    input  t_seg i_seg,
    pd_pt_out_if.source o_pt
);

    t_back_state r_state, n_state;
    logic signed [COORD_W-1:0] r_base_x, n_base_x, r_base_y, n_base_y;
    logic r_sgn_x, n_sgn_x, r_sgn_y, n_sgn_y;
    logic [DIV_W-1:0] r_quo_x, n_quo_x, r_quo_y, n_quo_y;
    logic [CNT_W-1:0] r_rem_x, n_rem_x, r_rem_y, n_rem_y;
    logic [CNT_W-1:0] r_n, n_n;
    logic r_clip, n_clip;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic signed [POS_W-1:0] r_qx, n_qx, r_qy, n_qy;
    logic [CNT_W:0] r_rdx, n_rdx, r_rdy, n_rdy;
    logic signed [POS_W-1:0] r_px, n_px, r_py, n_py;
    logic [CNT_W:0] r_rx, n_rx, r_ry, n_ry;
    logic [CNT_W-1:0] r_s, n_s;
    logic r_o_valid, n_o_valid;
    logic signed [COORD_W-1:0] r_o_x, n_o_x, r_o_y, n_o_y;
    logic r_o_last, n_o_last, r_o_clip, n_o_clip;

    // divider step
    logic [CNT_W:0] dtx, dty;
    logic gex, gey;
    logic [CNT_W:0] dsx, dsy;
    // sign fixup
    logic signed [POS_W-1:0] qux, quy, fqx, fqy;
    logic [CNT_W-1:0] frx, fry;
    // point step
    logic [CNT_W+1:0] txx, txy, two_n, tsx, tsy;
    logic wrx, wry;
    logic [CNT_W:0] rxn, ryn;
    logic signed [POS_W-1:0] pxn, pyn;
    logic [CNT_W-1:0] s_inc;
    logic last, out_take;

    always_comb begin
        dtx = {r_rem_x, r_quo_x[DIV_W-1]};
        dty = {r_rem_y, r_quo_y[DIV_W-1]};
        gex = (dtx >= {1'b0, r_n});
        gey = (dty >= {1'b0, r_n});
        dsx = dtx - {1'b0, r_n};
        dsy = dty - {1'b0, r_n};

        // floor division: negative delta with remainder rounds the quotient down
        qux = $signed({2'b00, r_quo_x});
        quy = $signed({2'b00, r_quo_y});
        fqx = r_sgn_x ? ((r_rem_x == '0) ? -qux : ~qux) : qux;
        fqy = r_sgn_y ? ((r_rem_y == '0) ? -quy : ~quy) : quy;
        frx = (r_sgn_x && r_rem_x != '0) ? (r_n - r_rem_x) : r_rem_x;
        fry = (r_sgn_y && r_rem_y != '0) ? (r_n - r_rem_y) : r_rem_y;

        // running remainder kept in [0, 2n)
        two_n = {1'b0, r_n, 1'b0};
        txx = {1'b0, r_rx} + {1'b0, r_rdx};
        txy = {1'b0, r_ry} + {1'b0, r_rdy};
        wrx = (txx >= two_n);
        wry = (txy >= two_n);
        tsx = txx - two_n;
        tsy = txy - two_n;
        rxn = wrx ? tsx[CNT_W:0] : txx[CNT_W:0];
        ryn = wry ? tsy[CNT_W:0] : txy[CNT_W:0];
        pxn = r_px + r_qx + $signed({{(POS_W-1){1'b0}}, wrx});
        pyn = r_py + r_qy + $signed({{(POS_W-1){1'b0}}, wry});
        s_inc = r_s + CNT_W'(1);
        last  = (s_inc == r_n);
        out_take = !r_o_valid || o_pt.ready;
    end

    always_comb begin
        n_state  = r_state;
        n_base_x = r_base_x;
        n_base_y = r_base_y;
        n_sgn_x  = r_sgn_x;
        n_sgn_y  = r_sgn_y;
        n_quo_x  = r_quo_x;
        n_quo_y  = r_quo_y;
        n_rem_x  = r_rem_x;
        n_rem_y  = r_rem_y;
        n_n      = r_n;
        n_clip   = r_clip;
        n_dcnt   = r_dcnt;
        n_qx     = r_qx;
        n_qy     = r_qy;
        n_rdx    = r_rdx;
        n_rdy    = r_rdy;
        n_px     = r_px;
        n_py     = r_py;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_s      = r_s;
        n_o_valid = r_o_valid;
        n_o_x    = r_o_x;
        n_o_y    = r_o_y;
        n_o_last = r_o_last;
        n_o_clip = r_o_clip;
        o_seg_ready = (r_state == B_IDLE);
        if (r_o_valid && o_pt.ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            B_IDLE: begin
                if (i_seg_valid) begin
                    n_base_x = i_seg.base_x;
                    n_base_y = i_seg.base_y;
                    n_sgn_x  = i_seg.dx[DELTA_W-1];
                    n_sgn_y  = i_seg.dy[DELTA_W-1];
                    n_quo_x  = abs_delta(i_seg.dx);
                    n_quo_y  = abs_delta(i_seg.dy);
                    n_rem_x  = '0;
                    n_rem_y  = '0;
                    n_n      = i_seg.n;
                    n_clip   = i_seg.clip;
                    n_dcnt   = '0;
                    // a single point needs no division
                    n_state  = (i_seg.n == CNT_W'(1)) ? B_FIX : B_DIV;
                end
            end
            B_DIV: begin
                n_quo_x = {r_quo_x[DIV_W-2:0], gex};
                n_quo_y = {r_quo_y[DIV_W-2:0], gey};
                n_rem_x = gex ? dsx[CNT_W-1:0] : dtx[CNT_W-1:0];
                n_rem_y = gey ? dsy[CNT_W-1:0] : dty[CNT_W-1:0];
                n_dcnt  = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(DIV_W - 1)) begin
                    n_state = B_FIX;
                end
            end
            B_FIX: begin
                n_qx  = fqx;
                n_qy  = fqy;
                n_rdx = {frx, 1'b0};
                n_rdy = {fry, 1'b0};
                n_px  = {{(POS_W-COORD_W){r_base_x[COORD_W-1]}}, r_base_x};
                n_py  = {{(POS_W-COORD_W){r_base_y[COORD_W-1]}}, r_base_y};
                n_rx  = {1'b0, r_n};
                n_ry  = {1'b0, r_n};
                n_s   = '0;
                n_state = B_EMIT;
            end
            B_EMIT: begin
                if (out_take) begin
                    n_rx      = rxn;
                    n_ry      = ryn;
                    n_px      = pxn;
                    n_py      = pyn;
                    n_o_valid = 1'b1;
                    n_o_x     = pxn[COORD_W-1:0];
                    n_o_y     = pyn[COORD_W-1:0];
                    n_o_last  = last;
                    n_o_clip  = r_clip;
                    n_s       = s_inc;
                    if (last) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_pt.valid       = r_o_valid;
    assign o_pt.out_x       = r_o_x;
    assign o_pt.out_y       = r_o_y;
    assign o_pt.last_of_run = r_o_last;
    assign o_pt.clipped     = r_o_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_x <= n_base_x;
        r_base_y <= n_base_y;
        r_sgn_x  <= n_sgn_x;
        r_sgn_y  <= n_sgn_y;
        r_quo_x  <= n_quo_x;
        r_quo_y  <= n_quo_y;
        r_rem_x  <= n_rem_x;
        r_rem_y  <= n_rem_y;
        r_n      <= n_n;
        r_clip   <= n_clip;
        r_dcnt   <= n_dcnt;
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_rdx    <= n_rdx;
        r_rdy    <= n_rdy;
        r_px     <= n_px;
        r_py     <= n_py;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_s      <= n_s;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_o_last <= n_o_last;
        r_o_clip <= n_o_clip;
    end

`ifndef ASSERT_OFF
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_s < r_n))
        else $error("point index past segment count");
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_rx < {r_n, 1'b0} && r_rdx < {r_n, 1'b0}))
        else $error("x interpolation remainder out of range");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_ry < {r_n, 1'b0} && r_rdy < {r_n, 1'b0}))
        else $error("y interpolation remainder out of range");
`endif

endmodule

[hw/rtl/polyline_densifier_core.sv]
// top level of the polyline densifier: config register, front, queue and back
//
// polyline densifier: takes path waypoints (signed fixed point metres) one item
// at a time and emits points spaced at most one step apart, where step is
// max(0.05 m, grid_resolution / 2). the first waypoint of a path (path_start,
// or the first item after reset) is passed through as a single point. for a
// later waypoint the segment from the previous waypoint is cut into n equal
// parts, n being the smallest count whose total length reaches the distance;
// the run ends exactly on the waypoint and carries last_of_run on its final
// point. if even MAX_SEGMENTS steps fall short, n is MAX_SEGMENTS and every
// point of the run carries clipped. the front squares dx and dy on a shared
// 32x32 squarer and sums them, then tests one count at a time, squaring its
// total length and comparing it with the distance. the back runs a one bit
// per cycle long division of both deltas by n, skipped for a single point run,
// then emits one point per cycle while the output is not stalled. a two entry
// queue lets front and back overlap. grid_resolution may be written only
// while the block holds no item in flight.
module polyline_densifier_core import pd_pkg::*; #(
    parameter int MAX_SEGMENTS = PD_MAX_SEGMENTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [RES_W-1:0] i_cfg_wdata,
    pd_pt_in_if.sink         i_pt,
    pd_pt_out_if.source      o_pt
);

    // map cell size, sets the step length
    logic [RES_W-1:0] r_grid_res;

    // front to queue
    logic f_valid, f_ready;
    t_seg f_seg;
    // queue to back
    logic b_valid, b_ready;
    t_seg b_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_res <= GRID_RES_RESET;
        end else if (i_cfg_we) begin
            r_grid_res <= i_cfg_wdata;
        end
    end

    // classification and segment count search
    pd_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_res  (r_grid_res),
        .i_pt        (i_pt),
        .o_seg_valid (f_valid),
        .i_seg_ready (f_ready),
        .o_seg       (f_seg)
    );

    // decouples the search from the point emission
    pd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_seg),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (b_seg)
    );

    // division and interpolation, output register inside
    pd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (b_valid),
        .o_seg_ready (b_ready),
        .i_seg       (b_seg),
        .o_pt        (o_pt)
    );

endmodule
